@@ sv/skl_pkg.sv @@
// Package with the shared types and codes of the sorted key list.
package skl_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;
   typedef logic signed [31:0] key_type;
   typedef logic [4:0] field_count_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_POP    = 2'd2;
   localparam op_type OP_SEARCH = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;
   localparam status_type ST_MISSING = 2'd3;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_type;

endpackage

@@ sv/skl_if.sv @@
// Request and response channel interfaces of the sorted key list.
interface skl_req_if import skl_pkg::*; ();
   logic    valid;
   logic    ready;
   op_type  operation;
   key_type key;

   modport source (output valid, output operation, output key, input ready);
   modport sink (input valid, input operation, input key, output ready);
endinterface

interface skl_rsp_if import skl_pkg::*; ();
   logic            valid;
   logic            ready;
   status_type      status;
   key_type         result_key;
   field_count_type position;
   field_count_type entry_count;

   modport source (output valid, output status, output result_key, output position,
                   output entry_count, input ready);
   modport sink (input valid, input status, input result_key, input position,
                 input entry_count, output ready);
endinterface

@@ sv/skl_cmp.sv @@
// Shared signed key comparator used by every scan step.
module skl_cmp import skl_pkg::*; (
   input  key_type a,
   input  key_type b,
   output cmp_type result
);

   assign result.less  = (a < b);
   assign result.equal = (a == b);

endmodule

@@ sv/sorted_key_list_top.sv @@
// Top level of the sorted key list: sequencer, key memory and result register.
//
// The block keeps up to CAPACITY signed keys in ascending order in a key
// memory with one write port and a registered read. Each request transaction
// carries an operation (insert, remove matching key, pop smallest, search)
// and a key. Each request yields exactly one response transaction with a
// status, the key concerned, its sorted position and the entry count after
// the operation.
// One request is handled at a time; req_chan.ready is high only while the
// sequencer is idle. Every step reads one entry and compares it with the
// operand in the shared comparator, in a read state and an evaluate state.
// An insert walks down from the top, moving entries that are not smaller
// than the key up one place. Remove and pop scan the whole occupied range
// and close the gap on the way. A search stops at the first match; a miss
// scans the whole range. Errors (full, empty) go straight to the done
// state. The response is held in an output register, so a new request is
// taken while it waits; a stalled receiver only delays the end of the
// following request.
// Reset clears the count and the response valid; no memory clearing pass.
module sorted_key_list_top import skl_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   skl_req_if.sink    req_chan,
   skl_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INS_RD = 3'd1;
   localparam logic [2:0] S_INS_EV = 3'd2;
   localparam logic [2:0] S_SCN_RD = 3'd3;
   localparam logic [2:0] S_SCN_EV = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] idx_dec;
   op_type           op_ff, op_in;
   key_type          key_ff, key_in;
   key_type          rkey_ff, rkey_in;
   status_type       status_ff, status_in;
   logic             found_ff, found_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   key_type          rsp_key_ff, rsp_key_in;
   field_count_type  rsp_pos_ff, rsp_pos_in;
   field_count_type  rsp_count_ff, rsp_count_in;

   key_type          mem [CAPACITY];
   key_type          mem_rd_ff;
   logic [IDX_W-1:0] mem_ra;
   logic [IDX_W-1:0] mem_wa;
   key_type          mem_wd;
   logic             mem_we;

   cmp_type          cmp;
   logic             req_fire;
   logic             rsp_free;

   skl_cmp u_cmp (
      .a      (mem_rd_ff),
      .b      (key_ff),
      .result (cmp)
   );

   assign idx_dec  = idx_ff - 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.result_key  = rsp_key_ff;
   assign rsp_chan.position    = rsp_pos_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      rkey_in       = rkey_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      mem_ra        = idx_ff[IDX_W-1:0];
      mem_wa        = idx_ff[IDX_W-1:0];
      mem_wd        = key_ff;
      mem_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_chan.operation;
               key_in    = req_chan.key;
               rkey_in   = '0;
               pos_in    = '0;
               status_in = ST_OK;
               found_in  = 1'b0;
               idx_in    = '0;
               case (req_chan.operation)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = ST_MISSING;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCN_RD;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCN_RD;
                     end
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               pos_in   = '0;
               rkey_in  = key_ff;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               mem_ra   = idx_dec[IDX_W-1:0];
               state_in = S_INS_EV;
            end
         end
         S_INS_EV: begin
            mem_we = 1'b1;
            if (!cmp.less) begin
               mem_wd   = mem_rd_ff;
               idx_in   = idx_dec;
               state_in = S_INS_RD;
            end else begin
               pos_in   = idx_ff;
               rkey_in  = key_ff;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end
         end
         S_SCN_RD: begin
            if (idx_ff == count_ff) begin
               if (found_ff) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  status_in = ST_MISSING;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_SCN_EV;
            end
         end
         S_SCN_EV: begin
            idx_in   = idx_ff + 1'b1;
            state_in = S_SCN_RD;
            if (found_ff) begin
               mem_we = 1'b1;
               mem_wa = idx_dec[IDX_W-1:0];
               mem_wd = mem_rd_ff;
            end else if (cmp.equal || op_ff == OP_POP) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
               rkey_in  = mem_rd_ff;
               if (op_ff == OP_SEARCH) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_key_in    = rkey_ff;
               rsp_pos_in    = 5'(pos_ff);
               rsp_count_in  = 5'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      rkey_ff       <= rkey_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

@@ sv/skl_checker.sv @@
// Port-level assertions for the sorted key list and their bind statement.
module skl_checker import skl_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input status_type      rsp_status,
   input key_type         rsp_key,
   input field_count_type rsp_position,
   input field_count_type rsp_count
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken while a transaction is in progress.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_key)
         && $stable(rsp_position) && $stable(rsp_count))
      else $error("Stalled response changed.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_count == 5'(CAPACITY) && rsp_key == '0 && rsp_position == '0)
      else $error("Full status with wrong count or nonzero fields.");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_count == '0 && rsp_key == '0 && rsp_position == '0)
      else $error("Empty status with nonzero fields.");

endmodule

bind sorted_key_list_top skl_checker #(.CAPACITY(CAPACITY)) u_skl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_key      (rsp_chan.result_key),
   .rsp_position (rsp_chan.position),
   .rsp_count    (rsp_chan.entry_count)
);

@@ sim/skl_reply_checker.sv @@
// Checker that predicts every sorted key list response and compares it with the block's.
module skl_reply_checker import skl_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   skl_req_if          req_mon,
   skl_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned replies_pending
);

   typedef struct packed {
      status_type      status;
      key_type         result_key;
      field_count_type position;
      field_count_type entry_count;
   } list_reply_type;

   key_type        list_keys [CAPACITY];
   int             list_len;
   list_reply_type expected_replies [$];
   int unsigned    requests_seen;
   int unsigned    replies_seen;

   assign replies_pending = requests_seen - replies_seen;

   function automatic int find_key(key_type k);
      for (int idx = 0; idx < list_len; idx++) begin
         if (list_keys[idx] == k) begin
            return idx;
         end
      end
      return -1;
   endfunction

   function automatic void delete_slot(int slot);
      for (int idx = slot; idx + 1 < list_len; idx++) begin
         list_keys[idx] = list_keys[idx + 1];
      end
      list_len--;
   endfunction

   function automatic list_reply_type apply_list_op(op_type op, key_type k);
      list_reply_type reply;
      int             slot;
      reply = '0;
      reply.status = ST_OK;
      slot = 0;
      case (op)
         OP_INSERT: begin
            if (list_len >= CAPACITY) begin
               reply.status = ST_FULL;
            end else begin
               while (slot < list_len && list_keys[slot] < k) begin
                  slot++;
               end
               for (int idx = list_len; idx > slot; idx--) begin
                  list_keys[idx] = list_keys[idx - 1];
               end
               list_keys[slot] = k;
               list_len++;
               reply.result_key = k;
               reply.position = field_count_type'(slot);
            end
         end
         OP_REMOVE: begin
            if (list_len == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               slot = find_key(k);
               if (slot < 0) begin
                  reply.status = ST_MISSING;
               end else begin
                  reply.result_key = k;
                  reply.position = field_count_type'(slot);
                  delete_slot(slot);
               end
            end
         end
         OP_POP: begin
            if (list_len == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.result_key = list_keys[0];
               delete_slot(0);
            end
         end
         default: begin
            slot = find_key(k);
            if (slot < 0) begin
               reply.status = ST_MISSING;
            end else begin
               reply.result_key = k;
               reply.position = field_count_type'(slot);
            end
         end
      endcase
      reply.entry_count = field_count_type'(list_len);
      return reply;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got;
      if (reset) begin
         list_len = 0;
         expected_replies.delete();
         mismatch_count = 0;
         requests_seen <= 0;
         replies_seen <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            replies_seen <= replies_seen + 1;
            got.status = rsp_mon.status;
            got.result_key = rsp_mon.result_key;
            got.position = rsp_mon.position;
            got.entry_count = rsp_mon.entry_count;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected response: status %0d key %0d",
                           got.status, got.result_key,
                           " position %0d count %0d", got.position, got.entry_count);
               end
            end else begin
               want = expected_replies.pop_front();
               if (got.status !== want.status || got.result_key !== want.result_key ||
                   got.position !== want.position || got.entry_count !== want.entry_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Response mismatch: expected status %0d key %0d",
                              want.status, want.result_key,
                              " position %0d count %0d,", want.position, want.entry_count,
                              " got status %0d key %0d", got.status, got.result_key,
                              " position %0d count %0d", got.position, got.entry_count);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            requests_seen <= requests_seen + 1;
            expected_replies.push_back(apply_list_op(req_mon.operation, req_mon.key));
         end
      end
   end

endmodule

@@ sim/tb_sorted_key_list_top.sv @@
// Testbench top for the sorted key list: clock, reset, stimulus, response pacing and verdict.
module tb_sorted_key_list_top;
   import skl_pkg::*;

   localparam int      CAPACITY     = 16;
   localparam int      RANDOM_ITEMS = 1525;
   localparam int      IDLE_LIMIT   = 2000;
   localparam key_type KEY_MIN      = 32'sh8000_0000;
   localparam key_type KEY_MAX      = 32'sh7fff_ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned mismatch_count;
   int unsigned replies_pending;
   int          sender_streak;
   int          receiver_streak;
   int          idle_cycles;

   skl_req_if req_chan ();
   skl_rsp_if rsp_chan ();

   sorted_key_list_top #(.CAPACITY(CAPACITY)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   skl_reply_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .replies_pending (replies_pending)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait(inout int streak);
      if (streak > 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         streak = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // Mostly a small pool so that duplicates, hits and misses all occur.
   function automatic key_type pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return key_type'($urandom_range(0, 7)) - 4;
         6: begin
            case ($urandom_range(0, 3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return key_type'($urandom());
      endcase
   endfunction

   task automatic send_request(input op_type op, input key_type k);
      int gap;
      gap = draw_wait(sender_streak);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.key <= k;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
   endtask

   initial begin
      bit     filling;
      int     pick;
      op_type op;
      req_chan.valid <= 1'b0;
      req_chan.operation <= OP_INSERT;
      req_chan.key <= '0;
      sender_streak = 0;
      filling = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_SEARCH, '0);
      send_request(OP_REMOVE, 1);
      send_request(OP_POP, -1);
      send_request(OP_INSERT, 5);
      send_request(OP_INSERT, 5);
      send_request(OP_INSERT, KEY_MIN);
      send_request(OP_INSERT, KEY_MAX);
      send_request(OP_INSERT, '0);
      send_request(OP_INSERT, -1);
      repeat (CAPACITY - 6) send_request(OP_INSERT, key_type'($urandom_range(0, 7)) - 4);
      send_request(OP_INSERT, 9);
      send_request(OP_SEARCH, 5);
      send_request(OP_SEARCH, 7);
      send_request(OP_REMOVE, 7);
      send_request(OP_REMOVE, 5);
      send_request(OP_POP, '0);
      wait_for_drain();

      // Alternate insert-heavy and removal-heavy stretches to hit full and empty.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 48 == 0) begin
            filling = ~filling;
         end
         if (n == RANDOM_ITEMS / 2) begin
            wait_for_drain();
         end
         pick = $urandom_range(0, 99);
         if (filling) begin
            op = (pick < 60) ? OP_INSERT : (pick < 75) ? OP_REMOVE : (pick < 85) ? OP_POP :
                 OP_SEARCH;
         end else begin
            op = (pick < 15) ? OP_INSERT : (pick < 50) ? OP_REMOVE : (pick < 80) ? OP_POP :
                 OP_SEARCH;
         end
         send_request(op, (op == OP_POP) ? key_type'($urandom()) : pick_key());
      end

      wait_for_drain();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      receiver_streak = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(receiver_streak);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
